FILE: sv/rdsb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdsb_pkg
// Shared types and register indexes for the RGB downscaler.
// ----------------------------------------------------------------------------
package rdsb_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 28;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_X_STEP     = 3'd4,
        REG_Y_STEP     = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CALC, ST_WRITE} t_state;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       row_end;
        logic       frame_end;
    } t_out_word;

endpackage
`default_nettype wire

FILE: sv/rdsb_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdsb_stream_if
// Valid/ready channel carrying one packed word.
// ----------------------------------------------------------------------------
interface rdsb_stream_if #(
    parameter int unsigned WIDTH = 25
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/rgb_downscaler_box_bilinear.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_downscaler_box_bilinear
// Streaming RGB downscaler: 2x2 box average or bilinear sampling.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order through i_pix; destination pixels
// leave through o_pix. A source word is accepted in IDLE and then runs
// through READ, CALC and WRITE: read the line buffer entry of its column
// (synchronous RAM), compute the weighted or box sum on the registered
// neighbours, then write back the word and present the result. No new word
// is taken before the current one leaves WRITE, as set by the read-modify-write
// of the single line buffer port and the two-stage multiply. A result waits
// in the output register; the write-back cycle repeats until the waiting
// result has been taken, or ends at once when the current word gives none.
// The line buffer needs no clearing: each entry is written in row zero before
// its value is used. The user must write configuration (i_cfg_we / i_cfg_idx /
// i_cfg_data) only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module rgb_downscaler_box_bilinear
    import rdsb_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 4096,
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    rdsb_stream_if.sink                i_pix,
    rdsb_stream_if.source              o_pix
);

    localparam int unsigned AW  = $clog2(MAX_WIDTH);
    localparam int unsigned PW  = 13 + CFG_DATA_W;  // position width
    localparam int unsigned WW  = FRAC_BITS + 1;    // weight width
    localparam int unsigned P1W = 8 + WW + 1;       // one-axis sum
    localparam int unsigned P2W = P1W + WW;         // two-axis sum
    localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

    // configuration
    logic [12:0] r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic [27:0] r_x_step, r_y_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= 13'd2; r_src_h <= 13'd2;
            r_dst_w <= 13'd1; r_dst_h <= 13'd1;
            r_x_step <= '0; r_y_step <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SRC_WIDTH:  r_src_w  <= i_cfg_data[12:0];
                REG_SRC_HEIGHT: r_src_h  <= i_cfg_data[12:0];
                REG_DST_WIDTH:  r_dst_w  <= i_cfg_data[12:0];
                REG_DST_HEIGHT: r_dst_h  <= i_cfg_data[12:0];
                REG_X_STEP:     r_x_step <= i_cfg_data;
                REG_Y_STEP:     r_y_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // line buffer
    logic [23:0] mem [MAX_WIDTH];
    logic [23:0] r_rd;
    logic        mem_we;
    logic [AW-1:0] mem_addr;

    // state
    t_state      r_state, n_state;
    logic [23:0] r_prev, r_aleft, r_cur;
    logic [12:0] r_scol, r_srow, r_dcol, r_drow;
    logic [PW-1:0] r_xpos, r_ypos;
    logic        r_fs;
    t_out_word   r_out;
    logic        r_ovalid;

    // decision latched in CALC
    logic r_emit, r_box_mode, r_rend, r_fend;
    logic [12:0] r_ncol, r_nrow, r_ndcol, r_ndrow;
    logic [PW-1:0] r_nx, r_ny;
    logic r_wrap;

    // pixel latched in IDLE, restart folded in
    t_in_word in_w;
    assign in_w = t_in_word'(i_pix.data);

    logic [12:0] col, row;
    logic [PW-1:0] xpos, ypos;
    logic [12:0] dcol, drow;
    assign col  = r_fs ? '0 : r_scol;
    assign row  = r_fs ? '0 : r_srow;
    assign xpos = r_fs ? '0 : r_xpos;
    assign ypos = r_fs ? '0 : r_ypos;
    assign dcol = r_fs ? '0 : r_dcol;
    assign drow = r_fs ? '0 : r_drow;

    logic cfg_ok, box;
    always_comb begin
        cfg_ok = (r_src_w != 0) && (r_src_h != 0) && (r_dst_w != 0) && (r_dst_h != 0)
              && ({1'b0, r_src_w} <= 14'(MAX_WIDTH))
              && (r_dst_w <= r_src_w) && (r_dst_h <= r_src_h)
              && !(r_dst_w > 13'd1 && r_x_step < 28'(ONE))
              && !(r_dst_h > 13'd1 && r_y_step < 28'(ONE));
        box = ({1'b0, r_src_w} == {r_dst_w, 1'b0}) && ({1'b0, r_src_h} == {r_dst_h, 1'b0});
    end

    // split positions into emission coordinate and fraction
    logic [PW-1:0] xip_w, yip_w;
    logic [FRAC_BITS-1:0] dx, dy;
    logic [12:0] ex, ey;
    logic xnear, ynear;
    always_comb begin
        xip_w = xpos >> FRAC_BITS;
        yip_w = ypos >> FRAC_BITS;
        dx = xpos[FRAC_BITS-1:0];
        dy = ypos[FRAC_BITS-1:0];
        ex = xip_w[12:0];
        ey = yip_w[12:0];
        if (xip_w >= PW'(r_src_w - 13'd1)) begin ex = r_src_w - 13'd1; dx = '0; end
        if (yip_w >= PW'(r_src_h - 13'd1)) begin ey = r_src_h - 13'd1; dy = '0; end
        xnear = (dx == '0);
        ynear = (dy == '0);
        if (!xnear) ex = ex + 13'd1;
        if (!ynear) ey = ey + 13'd1;
    end

    logic use_box, use_bil, emit;
    assign use_box = cfg_ok && box && col[0] && row[0];
    assign use_bil = cfg_ok && !box && (drow < r_dst_h) && (ex == col) && (ey == row);
    assign emit    = use_box || use_bil;

    // columns past the line buffer read as zero
    logic [23:0] above;
    assign above = ({1'b0, col} < 14'(MAX_WIDTH)) ? r_rd : 24'd0;

    // stage 1 (CALC): horizontal blend, registered
    logic [P1W-1:0] r_top [3], r_bot [3];
    logic [FRAC_BITS-1:0] r_dy;
    logic [9:0] r_box [3];
    logic [23:0] tl, tr, bl, br;
    always_comb begin
        if (box) begin
            tl = r_aleft; tr = above; bl = r_prev; br = r_cur;
        end else begin
            bl = xnear ? r_cur : r_prev;
            br = r_cur;
            tl = ynear ? bl : (xnear ? above : r_aleft);
            tr = ynear ? r_cur : above;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC) begin
            r_dy <= dy;
            for (int k = 0; k < 3; k++) begin
                r_top[k] <= P1W'(tl[16-8*k +: 8]) * P1W'(ONE - WW'(dx))
                          + P1W'(tr[16-8*k +: 8]) * P1W'(dx);
                r_bot[k] <= P1W'(bl[16-8*k +: 8]) * P1W'(ONE - WW'(dx))
                          + P1W'(br[16-8*k +: 8]) * P1W'(dx);
                r_box[k] <= 10'(tl[16-8*k +: 8]) + 10'(tr[16-8*k +: 8])
                          + 10'(bl[16-8*k +: 8]) + 10'(br[16-8*k +: 8]) + 10'd2;
            end
        end
    end

    // stage 2 (WRITE): vertical blend and rounding
    logic [7:0] res [3];
    logic [P2W-1:0] v;
    always_comb begin
        v = '0;
        for (int k = 0; k < 3; k++) begin
            v = P2W'(r_top[k]) * P2W'(ONE - WW'(r_dy)) + P2W'(r_bot[k]) * P2W'(r_dy)
              + (P2W'(1) << (2*FRAC_BITS - 1));
            v = v >> (2*FRAC_BITS);
            res[k] = r_box_mode ? r_box[k][9:2] : ((v > P2W'(255)) ? 8'hFF : v[7:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC) begin
            logic [12:0] c, r, dc, dr;
            logic [PW-1:0] nx, ny;
            logic re, fe;
            c = col + 13'd1; r = row;
            if (c >= r_src_w) begin c = '0; r = row + 13'd1; end
            dc = dcol; dr = drow; nx = xpos; ny = ypos; re = 1'b0; fe = 1'b0;
            if (use_box) begin
                re = (col + 13'd1 >= r_src_w);
                fe = re && (row + 13'd1 >= r_src_h);
            end else if (use_bil) begin
                dc = dcol + 13'd1;
                if (r_dst_w > 13'd1) nx = xpos + PW'(r_x_step);
                if (dc >= r_dst_w) begin
                    re = 1'b1; dc = '0; nx = '0; dr = drow + 13'd1;
                    if (r_dst_h > 13'd1) ny = ypos + PW'(r_y_step);
                    if (dr >= r_dst_h) fe = 1'b1;
                end
            end
            r_emit <= emit; r_box_mode <= box; r_rend <= re; r_fend <= fe;
            r_ncol <= c; r_nrow <= r; r_ndcol <= dc; r_ndrow <= dr;
            r_nx <= nx; r_ny <= ny; r_wrap <= (r >= r_src_h);
        end
    end

    // memory port
    assign mem_addr = (r_state == ST_WRITE) ? r_scol[AW-1:0] : col[AW-1:0];
    assign mem_we   = (r_state == ST_WRITE) && ({1'b0, r_scol} < 14'(MAX_WIDTH));
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= r_cur;
        // hold the read word while the write-back waits on the output
        if (r_state != ST_WRITE) r_rd <= mem[mem_addr];
    end

    // control FSM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    logic out_free;
    assign out_free = !r_ovalid || o_pix.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_pix.valid) n_state = ST_READ;
            ST_READ:  n_state = ST_CALC;
            ST_CALC:  n_state = ST_WRITE;
            ST_WRITE: if (!r_emit || out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    assign i_pix.ready = (r_state == ST_IDLE);

    // latch word, commit counters, drive output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0; r_aleft <= '0; r_fs <= 1'b0;
            r_scol <= '0; r_srow <= '0; r_dcol <= '0; r_drow <= '0;
            r_xpos <= '0; r_ypos <= '0; r_ovalid <= 1'b0;
        end else begin
            if (o_pix.ready) r_ovalid <= 1'b0;
            if (r_state == ST_IDLE && i_pix.valid) begin
                r_cur <= {in_w.pixel_red, in_w.pixel_green, in_w.pixel_blue};
                r_fs  <= in_w.frame_start;
            end
            if (r_state == ST_WRITE && (!r_emit || out_free)) begin
                r_fs <= 1'b0;
                r_aleft <= ({1'b0, r_scol} < 14'(MAX_WIDTH)) ? r_rd : 24'd0;
                r_prev <= r_cur;
                if (r_wrap) begin
                    r_scol <= '0; r_srow <= '0; r_dcol <= '0; r_drow <= '0;
                    r_xpos <= '0; r_ypos <= '0;
                end else begin
                    r_scol <= r_ncol; r_srow <= r_nrow; r_dcol <= r_ndcol;
                    r_drow <= r_ndrow; r_xpos <= r_nx; r_ypos <= r_ny;
                end
                if (r_emit) begin
                    r_ovalid <= 1'b1;
                    r_out <= '{out_red: res[0], out_green: res[1], out_blue: res[2],
                               row_end: r_rend, frame_end: r_fend};
                end
            end
            // counters must use restarted values: fold frame start in READ
            if (r_state == ST_READ && r_fs) begin
                r_scol <= '0; r_srow <= '0; r_dcol <= '0; r_drow <= '0;
                r_xpos <= '0; r_ypos <= '0;
            end
        end
    end

    assign o_pix.valid = r_ovalid;
    assign o_pix.data  = r_out;

    // a new result never overwrites one still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_pix.ready) |=> (r_ovalid && $stable(r_out)))
        else $error("result overwritten while stalled");
    // source column stays inside the row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_src_w != 0 && $past(r_state) == ST_WRITE)
        |-> (r_scol < r_src_w || r_scol == 0))
        else $error("source column out of range");
    // input accepted only when idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> (r_state == ST_READ))
        else $error("accept outside idle");

endmodule
`default_nettype wire
